// File: src/smalm_pkg.sv
// Shared types, constants and helpers for the stereo moving-average level meter.
// No dependencies; every other file of the block but smalm_ram uses this package.
package smalm_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int LEVEL_W  = 15;

  // Default window depth (log2, per channel)
  localparam int DEFAULT_MAX_WINDOW_LOG2 = 8;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int DATA_W  = 32;
  localparam int WLOG_W  = 4;
  localparam int CHCNT_W = 2;

  localparam logic REG_WINDOW_LOG2   = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  localparam logic [WLOG_W-1:0]  WINDOW_LOG2_RST   = 4'd8;
  localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RST = 2'd2;

  // Output queue depth is fixed at three entries
  localparam int QCNT_W = 2;

  // Per-item control handed to each lane
  typedef struct packed {
    logic accept;    // item accepted this cycle
    logic write_en;  // lane stores its magnitude for this item
    logic copy;      // lane takes the left sum instead of its own
    logic clear;     // clearing sweep writes zero this cycle
  } lane_ctrl_t;

  // Status of the merging stage
  typedef struct packed {
    logic              can_take;  // room for one more item in flight
    logic [QCNT_W-1:0] count;     // items waiting in the output queue
  } merge_stat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;
  } level_pair_t;

  // Absolute value of a 16-bit sample, -32768 saturates to 32767
  function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] neg;
    neg = SAMPLE_W'(~x + SAMPLE_W'(1));
    if (!x[SAMPLE_W-1]) begin
      return x[MAG_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      return '1;
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

endpackage

// File: src/smalm_frame_if.sv
// Input channel: one stereo frame of signed samples per item.
// Depends on smalm_pkg for field widths.
interface smalm_frame_if;
  logic                                valid;
  logic                                ready;
  logic signed [smalm_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [smalm_pkg::SAMPLE_W-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// File: src/smalm_level_if.sv
// Output channel: one pair of channel levels per item.
// Depends on smalm_pkg for field widths.
interface smalm_level_if;
  logic                           valid;
  logic                           ready;
  logic [smalm_pkg::LEVEL_W-1:0]  level_left;
  logic [smalm_pkg::LEVEL_W-1:0]  level_right;

  modport source (output valid, level_left, level_right, input ready);
  modport sink   (input valid, level_left, level_right, output ready);
endinterface

// File: src/smalm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read and write at the same address in one cycle return the old contents.
module smalm_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/smalm_lane.sv
// One channel lane: window memory, magnitude, running-sum update.
// Depends on smalm_pkg and smalm_ram.
module smalm_lane #(
  parameter int MAX_WINDOW_LOG2 = smalm_pkg::DEFAULT_MAX_WINDOW_LOG2,
  localparam int SUM_W = MAX_WINDOW_LOG2 + smalm_pkg::MAG_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  smalm_pkg::lane_ctrl_t            ctrl,
  input  logic [MAX_WINDOW_LOG2-1:0]       pos,
  input  logic [MAX_WINDOW_LOG2-1:0]       clr_addr,
  input  logic [smalm_pkg::SAMPLE_W-1:0]   sample,
  input  logic [SUM_W-1:0]                 copy_sum,
  output logic                             done,
  output logic [SUM_W-1:0]                 sum_upd,
  output logic [SUM_W-1:0]                 sum_new
);
  import smalm_pkg::*;

  localparam int DEPTH = 1 << MAX_WINDOW_LOG2;

  logic                        v1;
  logic                        wr1;
  logic                        copy1;
  logic                        fwd1;
  logic [MAX_WINDOW_LOG2-1:0]  pos1;
  logic [MAG_W-1:0]            mag1;
  logic [MAG_W-1:0]            fwd_mag;
  logic [MAG_W-1:0]            rdata;
  logic [MAG_W-1:0]            old_mag;
  logic [SUM_W-1:0]            sum;
  logic                        ram_we;
  logic [MAX_WINDOW_LOG2-1:0]  ram_waddr;
  logic [MAG_W-1:0]            ram_wdata;

  // Update stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ctrl.accept;
    end
  end

  // Capture the item; flag a same-address write still in flight
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      mag1    <= magnitude(sample);
      pos1    <= pos;
      wr1     <= ctrl.write_en;
      copy1   <= ctrl.copy;
      fwd1    <= v1 && wr1 && (pos1 == pos);
      fwd_mag <= mag1;
    end
  end

  // Oldest value leaves the window, newest enters
  assign old_mag = fwd1 ? fwd_mag : rdata;
  assign sum_upd = sum - SUM_W'(old_mag) + SUM_W'(mag1);
  assign sum_new = copy1 ? copy_sum : sum_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (v1) begin
      sum <= sum_new;
    end
  end

  // Memory write: clearing sweep or the item's magnitude
  assign ram_we    = ctrl.clear | (v1 & wr1);
  assign ram_waddr = ctrl.clear ? clr_addr : pos1;
  assign ram_wdata = ctrl.clear ? '0 : mag1;

  smalm_ram #(
    .WIDTH (MAG_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctrl.accept),
    .raddr (pos),
    .rdata (rdata)
  );

  assign done = v1;

endmodule

// File: src/smalm_merge.sv
// Merging stage: turns the two lane sums into saturated levels and queues them.
// Depends on smalm_pkg and the level channel interface.
module smalm_merge #(
  parameter int MAX_WINDOW_LOG2 = smalm_pkg::DEFAULT_MAX_WINDOW_LOG2,
  localparam int SUM_W = MAX_WINDOW_LOG2 + smalm_pkg::MAG_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [SUM_W-1:0]              sum_left,
  input  logic [SUM_W-1:0]              sum_right,
  input  logic [smalm_pkg::WLOG_W-1:0]  shift,
  output smalm_pkg::merge_stat_t        stat,
  smalm_level_if.source                 levels
);
  import smalm_pkg::*;

  localparam int QDEPTH = 3;

  level_pair_t         queue [QDEPTH];
  level_pair_t         entry;
  logic [QCNT_W-1:0]   wr_ptr;
  logic [QCNT_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic                pop;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [SUM_W-1:0] s,
                                                  input logic [WLOG_W-1:0] n);
    logic [SUM_W-1:0] sh;
    sh = s >> n;
    if (|sh[SUM_W-1:LEVEL_W]) begin
      return '1;
    end else begin
      return sh[LEVEL_W-1:0];
    end
  endfunction

  // Mean level of each channel
  always_comb begin
    entry.left  = level_of(sum_left, shift);
    entry.right = level_of(sum_right, shift);
  end

  assign pop        = levels.valid & levels.ready;
  assign count_next = count + QCNT_W'(push) - QCNT_W'(pop);

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QCNT_W'(QDEPTH - 1)) ? '0 : wr_ptr + QCNT_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QCNT_W'(QDEPTH - 1)) ? '0 : rd_ptr + QCNT_W'(1);
      end
      count <= count_next;
    end
  end

  // Hold queued levels
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  assign levels.valid       = (count != '0);
  assign levels.level_left  = queue[rd_ptr].left;
  assign levels.level_right = queue[rd_ptr].right;

  // One more item may enter while queue plus update stage leave a slot free
  assign stat.can_take = ({1'b0, count} + {2'b0, push}) <= 3'(QDEPTH - 1);
  assign stat.count    = count;

endmodule

// File: src/stereo_moving_average_level_meter.sv
// Stereo moving-average level meter, top level.
// Depends on smalm_pkg, both channel interfaces, smalm_lane and smalm_merge.
//
// Usage:
//   samples: one stereo frame (left_sample, right_sample) per item, taken when
//     valid and ready are both high. levels: one pair of mean absolute levels
//     per frame, in order, handed over when valid and ready are both high.
//   APB port: window_log2 at byte 0, channel_count at byte 4, written at the
//     access phase; pready is always high and reads return the register.
//   Throughput: one frame per cycle while samples.ready stays high. Each
//     lane reads its window memory at the accept edge and writes the new
//     magnitude in the next cycle; a write to the address read in the same
//     cycle is forwarded around the memory.
//   Reset: the window memories are cleared by a sweep over all 2^MAX_WINDOW_LOG2
//     entries (256 by default), one entry per lane each cycle; samples.ready
//     stays low until it ends. Sums and window position reset to zero.
//   Stall: a three-entry output queue absorbs results while levels.ready is
//     low; samples.ready drops once queue and update stage hold three items.
module stereo_moving_average_level_meter #(
  parameter int MAX_WINDOW_LOG2 = smalm_pkg::DEFAULT_MAX_WINDOW_LOG2
) (
  input  logic                           clk,
  input  logic                           rst,
  smalm_frame_if.sink                    samples,
  smalm_level_if.source                  levels,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smalm_pkg::PADDR_W-1:0]  paddr,
  input  logic [smalm_pkg::DATA_W-1:0]   pwdata,
  output logic [smalm_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);
  import smalm_pkg::*;

  localparam int SUM_W = MAX_WINDOW_LOG2 + MAG_W;
  localparam int PW    = MAX_WINDOW_LOG2;

  logic [WLOG_W-1:0]   window_log2;
  logic [CHCNT_W-1:0]  channel_count;
  logic [WLOG_W-1:0]   eff_log2;
  logic                stereo;
  logic                cfg_wr;

  logic                clearing;
  logic [PW-1:0]       clr_addr;
  logic [PW-1:0]       pos;
  logic [PW-1:0]       pos_next;
  logic [PW:0]         pos_inc;
  logic [PW:0]         win_len;
  logic                accept;

  lane_ctrl_t          ctrl_left;
  lane_ctrl_t          ctrl_right;
  logic                done_left;
  logic                done_right;
  logic [SUM_W-1:0]    upd_left;
  logic [SUM_W-1:0]    upd_right;
  logic [SUM_W-1:0]    sum_left;
  logic [SUM_W-1:0]    sum_right;
  merge_stat_t         stat;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_log2   <= WINDOW_LOG2_RST;
      channel_count <= CHANNEL_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WINDOW_LOG2:   window_log2   <= pwdata[WLOG_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[CHCNT_W-1:0];
        default:           window_log2   <= window_log2;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LOG2:   prdata = DATA_W'(window_log2);
      REG_CHANNEL_COUNT: prdata = DATA_W'(channel_count);
      default:           prdata = '0;
    endcase
  end

  // Clamp the window length; channel counts of two and three mean stereo
  assign eff_log2 = (window_log2 > WLOG_W'(MAX_WINDOW_LOG2)) ?
                    WLOG_W'(MAX_WINDOW_LOG2) : window_log2;
  assign stereo   = channel_count[1];

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + PW'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Input handshake
  assign samples.ready = !clearing && stat.can_take;
  assign accept        = samples.valid && samples.ready;

  // Advance the shared window position, wrap at the window length
  assign pos_inc  = {1'b0, pos} + (PW + 1)'(1);
  assign win_len  = (PW + 1)'(1) << eff_log2;
  assign pos_next = (pos_inc >= win_len) ? '0 : pos_inc[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Lane control
  always_comb begin
    ctrl_left.accept    = accept;
    ctrl_left.write_en  = 1'b1;
    ctrl_left.copy      = 1'b0;
    ctrl_left.clear     = clearing;
    ctrl_right.accept   = accept;
    ctrl_right.write_en = stereo;
    ctrl_right.copy     = !stereo;
    ctrl_right.clear    = clearing;
  end

  smalm_lane #(
    .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
  ) u_lane_left (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl_left),
    .pos      (pos),
    .clr_addr (clr_addr),
    .sample   (samples.left_sample),
    .copy_sum ('0),
    .done     (done_left),
    .sum_upd  (upd_left),
    .sum_new  (sum_left)
  );

  smalm_lane #(
    .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
  ) u_lane_right (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl_right),
    .pos      (pos),
    .clr_addr (clr_addr),
    .sample   (samples.right_sample),
    .copy_sum (upd_left),
    .done     (done_right),
    .sum_upd  (upd_right),
    .sum_new  (sum_right)
  );

  smalm_merge #(
    .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (done_left),
    .sum_left  (sum_left),
    .sum_right (sum_right),
    .shift     (eff_log2),
    .stat      (stat),
    .levels    (levels)
  );

`ifndef SYNTH
  // No item enters during the clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("item accepted during clearing sweep");

  // Sweep ends only after the last entry was cleared
  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clr_addr) == '1))
    else $error("clearing sweep ended early");

  // Every accepted item reaches the update stage in both lanes next cycle
  a_lane_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done_left && done_right))
    else $error("lane update stage missed an item");

  // Output queue never overflows
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (done_left && (stat.count == 2'd3)) |-> (levels.valid && levels.ready))
    else $error("level queue overflow");

  // Right lane keeps its own sum in stereo and follows the left sum in mono
  a_mono_copy: assert property (@(posedge clk) disable iff (rst)
    done_right |-> (sum_right == ($past(stereo) ? upd_right : upd_left)))
    else $error("right lane sum does not follow its mode");
`endif

endmodule
